@@ rtl/core/pstrd_pkg.sv @@
package pstrd_pkg;

    localparam int unsigned WordW   = 32;
    localparam int unsigned QuotW   = 48;
    localparam int unsigned ClearW  = 16;
    localparam int unsigned StepW   = 64;
    localparam logic [WordW-1:0] IntIndefinite = 32'h8000_0000;

    typedef struct packed {
        logic             valid;
        logic             err;
        logic [WordW-1:0] dvs;
        logic [WordW-1:0] rem;
        logic [QuotW-1:0] work;
    } t_div_beat;

endpackage

@@ rtl/core/pstrd_in_if.sv @@
interface pstrd_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] rate_factor;
    logic [31:0] pitch_factor;
    logic [31:0] rate_divisor;
    modport source (output valid, rate_factor, pitch_factor, rate_divisor, input ready);
    modport sink   (input valid, rate_factor, pitch_factor, rate_divisor, output ready);
endinterface

@@ rtl/core/pstrd_out_if.sv @@
interface pstrd_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] step_value;
    logic        divide_error;
    modport source (output valid, step_value, divide_error, input ready);
    modport sink   (input valid, step_value, divide_error, output ready);
endinterface

@@ rtl/core/pstrd_fmul.sv @@
module pstrd_fmul (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [31:0]          i_a,
    input  logic [31:0]          i_b,
    input  logic [31:0]          i_dvs,
    output pstrd_pkg::t_div_beat o_beat
);
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [23:0] ma, mb;
    logic [7:0]  ea, eb;

    logic        r1_valid, r1_sign, r1_spec, r1_zero;
    logic [47:0] r1_p;
    logic signed [10:0] r1_e;
    logic [31:0] r1_dvs;

    logic        r2_valid, r2_sign, r2_spec, r2_zero;
    logic [47:0] r2_p;
    logic signed [10:0] r2_e;
    logic [31:0] r2_dvs;
    logic [5:0]  r2_l, n_l;

    logic        r3_valid, r3_sign, r3_spec, r3_zero, r3_big, r3_tiny;
    logic [24:0] r3_m;
    logic signed [10:0] r3_k;
    logic [31:0] r3_dvs;

    logic [47:0] pn;
    logic [24:0] n_m;
    logic signed [10:0] le;
    logic [5:0]  rsh;
    logic [31:0] mag, n_ip;
    pstrd_pkg::t_div_beat r_beat;

    always_comb begin
        ea = i_a[30:23];
        eb = i_b[30:23];
        ma = {(ea != 8'd0), i_a[22:0]};
        mb = {(eb != 8'd0), i_b[22:0]};
        a_nan  = (ea == 8'hff) && (i_a[22:0] != 23'd0);
        b_nan  = (eb == 8'hff) && (i_b[22:0] != 23'd0);
        a_inf  = (ea == 8'hff);
        b_inf  = (eb == 8'hff);
        a_zero = (i_a[30:0] == 31'd0);
        b_zero = (i_b[30:0] == 31'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r_beat.valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r_beat.valid <= r3_valid;
        end
        if (i_en) begin
            r1_sign <= i_a[31] ^ i_b[31];
            r1_spec <= a_nan | b_nan | a_inf | b_inf;
            r1_zero <= a_zero | b_zero;
            r1_p    <= ma * mb;
            r1_e    <= $signed({3'b000, (ea == 8'd0) ? 8'd1 : ea})
                     + $signed({3'b000, (eb == 8'd0) ? 8'd1 : eb}) - 11'sd300;
            r1_dvs  <= i_dvs;

            r2_sign <= r1_sign;
            r2_spec <= r1_spec;
            r2_zero <= r1_zero;
            r2_p    <= r1_p;
            r2_e    <= r1_e;
            r2_dvs  <= r1_dvs;
            r2_l    <= n_l;

            r3_sign <= r2_sign;
            r3_spec <= r2_spec;
            r3_zero <= r2_zero;
            r3_m    <= n_m;
            r3_k    <= le - 11'sd23;
            r3_big  <= (le >= 11'sd31);
            r3_tiny <= (le < -11'sd1);
            r3_dvs  <= r2_dvs;

            r_beat.err  <= (r3_dvs == 32'd0);
            r_beat.dvs  <= r3_dvs;
            r_beat.rem  <= '0;
            r_beat.work <= {n_ip, 16'd0};
        end
    end

    always_comb begin
        n_l = 6'd0;
        for (int i = 0; i < 48; i++) begin
            if (r1_p[i]) begin
                n_l = 6'(i);
            end
        end
    end

    always_comb begin
        pn  = r2_p << (6'd47 - r2_l);
        n_m = {1'b0, pn[47:24]} + 25'(pn[23] & ((|pn[22:0]) | pn[24]));
        le  = $signed({5'd0, r2_l}) + r2_e;
    end

    always_comb begin
        rsh = 6'(-r3_k);
        if (r3_k >= 11'sd0) begin
            mag = {7'd0, r3_m} << r3_k[2:0];
        end else begin
            mag = {7'd0, r3_m} >> rsh;
        end
        if (r3_spec) begin
            n_ip = pstrd_pkg::IntIndefinite;
        end else if (r3_zero || r3_tiny) begin
            n_ip = 32'd0;
        end else if (r3_big || mag[31]) begin
            n_ip = pstrd_pkg::IntIndefinite;
        end else if (r3_sign) begin
            n_ip = -mag;
        end else begin
            n_ip = mag;
        end
    end

    assign o_beat = r_beat;
endmodule

@@ rtl/core/pstrd_cell.sv @@
module pstrd_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  pstrd_pkg::t_div_beat i_beat,
    output pstrd_pkg::t_div_beat o_beat
);
    logic [32:0] trial;
    logic [33:0] diff;
    logic        ge;
    pstrd_pkg::t_div_beat r_beat, n_beat;

    always_comb begin
        trial = {i_beat.rem, i_beat.work[47]};
        diff  = {1'b0, trial} - {2'b00, i_beat.dvs};
        ge    = !diff[33];
        n_beat      = i_beat;
        n_beat.rem  = ge ? diff[31:0] : trial[31:0];
        n_beat.work = {i_beat.work[46:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat.valid <= 1'b0;
        end else if (i_en) begin
            r_beat.valid <= n_beat.valid;
        end
        if (i_en) begin
            r_beat.err  <= n_beat.err;
            r_beat.dvs  <= n_beat.dvs;
            r_beat.rem  <= n_beat.rem;
            r_beat.work <= n_beat.work;
        end
    end

    assign o_beat = r_beat;
endmodule

@@ rtl/core/pitch_step_rate_divider_unit.sv @@
// Channel | Dir | Payload
// i_in    | in  | rate_factor, pitch_factor, rate_divisor (32 bits each)
// o_out   | out | step_value (64 bits), divide_error (1 bit)
//
// One beat is accepted per cycle while the chain is not held (i_in.ready high).
// The chain is four float-multiply stages plus one divider cell per quotient bit (48).
// Reset is synchronous and clears only the valid bits along the chain.
// When a result waits at the output, the whole chain holds and i_in.ready drops.
module pitch_step_rate_divider_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pstrd_in_if.sink    i_in,
    pstrd_out_if.source o_out
);
    pstrd_pkg::t_div_beat beats [0:pstrd_pkg::QuotW];
    logic en;

    assign en = !beats[pstrd_pkg::QuotW].valid || o_out.ready;
    assign i_in.ready = en;

    pstrd_fmul u_fmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in.valid),
        .i_a     (i_in.rate_factor),
        .i_b     (i_in.pitch_factor),
        .i_dvs   (i_in.rate_divisor),
        .o_beat  (beats[0])
    );

    for (genvar g = 0; g < pstrd_pkg::QuotW; g++) begin : g_cell
        pstrd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_beat  (beats[g]),
            .o_beat  (beats[g+1])
        );
    end

    assign o_out.valid        = beats[pstrd_pkg::QuotW].valid;
    assign o_out.divide_error = beats[pstrd_pkg::QuotW].err;
    assign o_out.step_value   = beats[pstrd_pkg::QuotW].err ? '0
                              : {beats[pstrd_pkg::QuotW].work, 16'd0};
endmodule

@@ test/pitch_step_rate_divider_unit_tb.sv @@
`timescale 1ns / 100ps

module pitch_step_rate_divider_unit_tb;

    typedef struct {
        logic [31:0] rate_factor;
        logic [31:0] pitch_factor;
        logic [31:0] rate_divisor;
    } t_stim;

    typedef struct {
        logic [63:0] step_value;
        logic        divide_error;
    } t_step;

    localparam int unsigned CycleLimit = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    pstrd_in_if  in_ch ();
    pstrd_out_if out_ch ();

    pitch_step_rate_divider_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    t_stim       pending_q[$];
    t_step       step_q[$];
    int unsigned accepted_cnt = 0;
    int unsigned error_cnt = 0;
    int unsigned cycle_cnt = 0;
    int unsigned hold_cnt = 0;
    bit          hold_done = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Truncated int32 pattern of the product rounded once to single precision.
    function automatic logic [31:0] product_to_int(logic [31:0] a, logic [31:0] b);
        logic [23:0] ma, mb;
        logic [47:0] prod, rem, half;
        logic [24:0] q;
        logic [63:0] mag;
        int          ea, eb, e, k, s, sh;
        logic        neg;
        neg = a[31] ^ b[31];
        if ((a[30:23] == 8'hFF) || (b[30:23] == 8'hFF)) begin
            return pstrd_pkg::IntIndefinite;
        end
        if ((a[30:0] == 31'd0) || (b[30:0] == 31'd0)) begin
            return 32'd0;
        end
        ea = (a[30:23] == 8'd0) ? 1 : int'(a[30:23]);
        eb = (b[30:23] == 8'd0) ? 1 : int'(b[30:23]);
        ma = {(a[30:23] != 8'd0), a[22:0]};
        mb = {(b[30:23] != 8'd0), b[22:0]};
        prod = ma * mb;
        e = ea + eb - 300;
        k = 0;
        for (int i = 0; i < 48; i++) begin
            if (prod[i]) begin
                k = i;
            end
        end
        if (k + e < -1) begin
            return 32'd0;
        end
        s = k - 23;
        if (s > 0) begin
            q = 25'(prod >> s);
            rem = prod & ((48'd1 << s) - 48'd1);
            half = 48'd1 << (s - 1);
            if ((rem > half) || ((rem == half) && q[0])) begin
                q = q + 25'd1;
            end
            if (q[24]) begin
                q = q >> 1;
                s = s + 1;
            end
        end else begin
            q = 25'(prod);
            s = 0;
        end
        sh = e + s;
        if (sh >= 8) begin
            return pstrd_pkg::IntIndefinite;
        end
        if (sh >= 0) begin
            mag = 64'(q) << sh;
        end else if (sh <= -40) begin
            mag = 64'd0;
        end else begin
            mag = 64'(q) >> (-sh);
        end
        if (mag >= 64'h8000_0000) begin
            return pstrd_pkg::IntIndefinite;
        end
        return neg ? (32'd0 - mag[31:0]) : mag[31:0];
    endfunction

    function automatic t_step predict_step(t_stim it);
        t_step       r;
        logic [63:0] dividend;
        dividend = {product_to_int(it.rate_factor, it.pitch_factor), 32'd0};
        if (it.rate_divisor == 32'd0) begin
            r.step_value = 64'd0;
            r.divide_error = 1'b1;
        end else begin
            r.step_value = (dividend / {32'd0, it.rate_divisor}) & 64'hFFFF_FFFF_FFFF_0000;
            r.divide_error = 1'b0;
        end
        return r;
    endfunction

    function automatic int unsigned sender_idle_pct();
        if (accepted_cnt < 520) begin
            return 34;
        end
        if (accepted_cnt < 1040) begin
            return 62;
        end
        return 0;
    endfunction

    function automatic int unsigned receiver_idle_pct();
        if (accepted_cnt < 520) begin
            return 62;
        end
        if (accepted_cnt < 1040) begin
            return 34;
        end
        return 0;
    endfunction

    function automatic logic [31:0] rand_float();
        logic [31:0] f;
        f = $urandom;
        case ($urandom_range(0, 3))
            0: f[30:23] = 8'($urandom_range(100, 160));
            1: f[30:23] = 8'($urandom_range(120, 140));
            default: ;
        endcase
        return f;
    endfunction

    function automatic logic [31:0] rand_divisor();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'($urandom_range(1, 300));
            2: return 32'($urandom_range(1, 65535));
            default: return $urandom;
        endcase
    endfunction

    task automatic add_item(logic [31:0] a, logic [31:0] b, logic [31:0] d);
        t_stim it;
        it.rate_factor = a;
        it.pitch_factor = b;
        it.rate_divisor = d;
        pending_q.push_back(it);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                t_stim it;
                it.rate_factor = in_ch.rate_factor;
                it.pitch_factor = in_ch.pitch_factor;
                it.rate_divisor = in_ch.rate_divisor;
                step_q.push_back(predict_step(it));
                accepted_cnt <= accepted_cnt + 1;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if ((pending_q.size() > 0) && ($urandom_range(0, 99) >= sender_idle_pct())) begin
                    t_stim nx;
                    nx = pending_q.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.rate_factor <= nx.rate_factor;
                    in_ch.pitch_factor <= nx.pitch_factor;
                    in_ch.rate_divisor <= nx.rate_divisor;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (step_q.size() == 0) begin
                    $error("step_value: beat with no expectation, actual %h", out_ch.step_value);
                    error_cnt = error_cnt + 1;
                end else begin
                    t_step ex;
                    ex = step_q.pop_front();
                    if (out_ch.step_value !== ex.step_value) begin
                        $error("step_value: expected %h actual %h",
                               ex.step_value, out_ch.step_value);
                        error_cnt = error_cnt + 1;
                    end
                    if (out_ch.divide_error !== ex.divide_error) begin
                        $error("divide_error: expected %b actual %b",
                               ex.divide_error, out_ch.divide_error);
                        error_cnt = error_cnt + 1;
                    end
                end
            end
            if (!hold_done && (accepted_cnt >= 1100)) begin
                hold_cnt <= hold_cnt + 1;
                out_ch.ready <= 1'b0;
                if (hold_cnt >= 200) begin
                    hold_done <= 1'b1;
                end
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct());
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CycleLimit) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.rate_factor = 32'd0;
        in_ch.pitch_factor = 32'd0;
        in_ch.rate_divisor = 32'd0;
        out_ch.ready = 1'b0;

        add_item(32'h0000_0000, 32'h0000_0000, 32'h0000_0001);
        add_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_item(32'h7FC0_0000, 32'h3F80_0000, 32'h0000_0001);
        add_item(32'h7F80_0000, 32'h3F80_0000, 32'h0000_0002);
        add_item(32'hFF80_0000, 32'h0000_0000, 32'h0000_0003);
        add_item(32'hCF00_0000, 32'h3F80_0000, 32'h0000_0001);
        add_item(32'h4F00_0000, 32'h3F80_0000, 32'h0000_0001);
        add_item(32'h4EFF_FFFF, 32'h3F80_0000, 32'h0000_0001);
        add_item(32'hCEFF_FFFF, 32'h3F80_0000, 32'h0000_0007);
        add_item(32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h0000_0005);
        add_item(32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
        add_item(32'h007F_FFFF, 32'h7F00_0000, 32'h0000_0001);
        add_item(32'h3F7F_FFFF, 32'h3F80_0001, 32'h0000_0001);
        add_item(32'h3F7F_FFFF, 32'h3F7F_FFFF, 32'h0000_0001);
        add_item(32'h4040_0000, 32'hC000_0000, 32'h0000_0003);
        add_item(32'h42C8_0000, 32'h3F00_0000, 32'h0000_0000);
        add_item(32'h4B80_0001, 32'h3F80_0001, 32'h0001_0000);
        add_item(32'h4000_0000, 32'h3FC0_0000, 32'hFFFF_FFFF);
        add_item(32'h3F80_0000, 32'h3F80_0000, 32'h8000_0000);
        add_item(32'hBF80_0000, 32'h3F80_0000, 32'h0000_0001);
        for (int i = 0; i < 1530; i++) begin
            add_item(rand_float(), rand_float(), rand_divisor());
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait ((pending_q.size() == 0) && !in_ch.valid && (step_q.size() == 0));
        repeat (60) @(posedge i_clk);
        if (error_cnt == 0 && step_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/pstrd_pkg.sv
rtl/core/pstrd_in_if.sv
rtl/core/pstrd_out_if.sv
rtl/core/pstrd_fmul.sv
rtl/core/pstrd_cell.sv
rtl/core/pitch_step_rate_divider_unit.sv
test/pitch_step_rate_divider_unit_tb.sv
